/* rtl/sgw_pkg.sv */
// Shared constants, types and register codes of the spiral grid walker.
package sgw_pkg;

   localparam int MAX_DIM    = 128;
   localparam int DIM_W      = 8;    // grid size registers
   localparam int IDX_W      = 7;    // row and column of a cell
   localparam int POS_W      = 10;   // two's complement spiral position
   localparam int LEG_W      = 9;
   localparam int CNT_W      = 15;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIM_W-1:0] MAX_DIM_V  = DIM_W'(MAX_DIM);
   localparam logic [LEG_W-1:0] LEG_LIMIT  = LEG_W'(2 * MAX_DIM + 1);

   typedef enum logic [1:0] {
      REG_GRID_ROWS = 2'd0,
      REG_GRID_COLS = 2'd1,
      REG_START_ROW = 2'd2,
      REG_START_COL = 2'd3
   } csr_addr_type;

   typedef enum logic [1:0] {
      HEAD_RIGHT = 2'd0,
      HEAD_DOWN  = 2'd1,
      HEAD_LEFT  = 2'd2,
      HEAD_UP    = 2'd3
   } heading_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic [DIM_W-1:0] grid_rows;
      logic [DIM_W-1:0] grid_cols;
      logic [IDX_W-1:0] start_row;
      logic [IDX_W-1:0] start_col;
   } cfg_type;

   typedef struct packed {
      logic restart;   // begin a new walk, answer the start cell
      logic exhaust;   // answer exhausted
      logic step;      // advance the spiral by one position
   } cmd_type;

   typedef struct packed {
      logic active;    // walk has cells left
      logic found;     // this step lands on an in-grid cell
      logic runaway;   // this step ends the walk without a cell
   } status_type;

endpackage

/* rtl/sgw_req_if.sv */
// Request channel of the spiral grid walker.
interface sgw_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

/* rtl/sgw_rsp_if.sv */
// Result channel of the spiral grid walker.
interface sgw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sgw_pkg::IDX_W-1:0]    cell_row;
   logic [sgw_pkg::IDX_W-1:0]    cell_col;
   logic                         last_cell;
   logic                         exhausted;

   modport source (output valid, output cell_row, output cell_col, output last_cell,
                   output exhausted, input ready);
   modport sink   (input valid, input cell_row, input cell_col, input last_cell,
                   input exhausted, output ready);
endinterface

/* rtl/sgw_csr.sv */
// APB-style configuration registers of the spiral grid walker.
module sgw_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sgw_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sgw_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sgw_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output sgw_pkg::cfg_type                  cfg
);

   sgw_pkg::cfg_type       cfg_ff, cfg_in;
   sgw_pkg::csr_addr_type  reg_sel;
   logic                   wr_en;

   assign pready  = 1'b1;
   assign reg_sel = sgw_pkg::csr_addr_type'(paddr[3:2]);
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            sgw_pkg::REG_GRID_ROWS: cfg_in.grid_rows = pwdata[sgw_pkg::DIM_W-1:0];
            sgw_pkg::REG_GRID_COLS: cfg_in.grid_cols = pwdata[sgw_pkg::DIM_W-1:0];
            sgw_pkg::REG_START_ROW: cfg_in.start_row = pwdata[sgw_pkg::IDX_W-1:0];
            sgw_pkg::REG_START_COL: cfg_in.start_col = pwdata[sgw_pkg::IDX_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         sgw_pkg::REG_GRID_ROWS: prdata = sgw_pkg::CSR_DATA_W'(cfg_ff.grid_rows);
         sgw_pkg::REG_GRID_COLS: prdata = sgw_pkg::CSR_DATA_W'(cfg_ff.grid_cols);
         sgw_pkg::REG_START_ROW: prdata = sgw_pkg::CSR_DATA_W'(cfg_ff.start_row);
         sgw_pkg::REG_START_COL: prdata = sgw_pkg::CSR_DATA_W'(cfg_ff.start_col);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_rows <= sgw_pkg::DIM_W'(1);
         cfg_ff.grid_cols <= sgw_pkg::DIM_W'(1);
         cfg_ff.start_row <= '0;
         cfg_ff.start_col <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/sgw_ctrl.sv */
// Controller state machine of the spiral grid walker.
module sgw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_restart,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sgw_pkg::status_type   status,
   output sgw_pkg::cmd_type      cmd
);

   sgw_pkg::ctrl_state_type state_ff, state_in;
   logic                    restart_ff, restart_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == sgw_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      restart_in   = restart_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         sgw_pkg::ST_IDLE: begin
            if (req_valid) begin
               restart_in = req_restart;
               state_in   = sgw_pkg::ST_EXEC;
            end
         end
         sgw_pkg::ST_EXEC: begin
            // hold while the output register is still occupied
            if (out_free) begin
               if (restart_ff) begin
                  cmd.restart  = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = sgw_pkg::ST_IDLE;
               end else if (!status.active) begin
                  cmd.exhaust  = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = sgw_pkg::ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
                  if (status.found || status.runaway) begin
                     rsp_valid_in = 1'b1;
                     state_in     = sgw_pkg::ST_IDLE;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff <= restart_in;
   end

endmodule

/* rtl/sgw_dpath.sv */
// Spiral stepping datapath and result register of the spiral grid walker.
module sgw_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  sgw_pkg::cfg_type            cfg,
   input  sgw_pkg::cmd_type            cmd,
   output sgw_pkg::status_type         status,
   output logic [sgw_pkg::IDX_W-1:0]   cell_row,
   output logic [sgw_pkg::IDX_W-1:0]   cell_col,
   output logic                        last_cell,
   output logic                        exhausted
);

   localparam int POS_W = sgw_pkg::POS_W;
   localparam int DIM_W = sgw_pkg::DIM_W;
   localparam int IDX_W = sgw_pkg::IDX_W;
   localparam int LEG_W = sgw_pkg::LEG_W;
   localparam int CNT_W = sgw_pkg::CNT_W;

   logic [POS_W-1:0]     row_ff, row_in, col_ff, col_in;
   sgw_pkg::heading_type head_ff, head_in;
   logic [LEG_W-1:0]     leg_ff, leg_in, prog_ff, prog_in;
   logic                 legs_ff, legs_in;
   logic [CNT_W-1:0]     cells_ff, cells_in, total_ff, total_in;
   logic                 active_ff, active_in;
   logic [DIM_W-1:0]     span_r_ff, span_r_in, span_c_ff, span_c_in;

   logic [IDX_W-1:0]     out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic                 out_last_ff, out_last_in, out_ex_ff, out_ex_in;

   // restart view of the configuration
   logic [DIM_W-1:0]     lim_r, lim_c, lim_r_m1, lim_c_m1;
   logic [IDX_W-1:0]     sr, sc;
   logic                 empty_grid, single_cell;
   logic [2*DIM_W-1:0]   product;

   // one spiral step
   logic [POS_W-1:0]     nrow, ncol;
   logic [LEG_W-1:0]     prog_inc, nprog, nleg;
   sgw_pkg::heading_type nhead;
   logic                 nlegs, in_grid, runaway;
   logic [CNT_W-1:0]     cells_inc;
   logic                 still_active;

   assign lim_r       = (cfg.grid_rows > sgw_pkg::MAX_DIM_V) ? sgw_pkg::MAX_DIM_V
                                                              : cfg.grid_rows;
   assign lim_c       = (cfg.grid_cols > sgw_pkg::MAX_DIM_V) ? sgw_pkg::MAX_DIM_V
                                                              : cfg.grid_cols;
   assign lim_r_m1    = lim_r - DIM_W'(1);
   assign lim_c_m1    = lim_c - DIM_W'(1);
   assign sr          = ({1'b0, cfg.start_row} < lim_r) ? cfg.start_row : lim_r_m1[IDX_W-1:0];
   assign sc          = ({1'b0, cfg.start_col} < lim_c) ? cfg.start_col : lim_c_m1[IDX_W-1:0];
   assign empty_grid  = (lim_r == '0) | (lim_c == '0);
   assign single_cell = (lim_r == DIM_W'(1)) & (lim_c == DIM_W'(1));
   assign product     = lim_r * lim_c;

   always_comb begin
      nrow = row_ff;
      ncol = col_ff;
      case (head_ff)
         sgw_pkg::HEAD_RIGHT: ncol = col_ff + POS_W'(1);
         sgw_pkg::HEAD_DOWN:  nrow = row_ff + POS_W'(1);
         sgw_pkg::HEAD_LEFT:  ncol = col_ff - POS_W'(1);
         sgw_pkg::HEAD_UP:    nrow = row_ff - POS_W'(1);
      endcase
   end

   assign prog_inc = prog_ff + LEG_W'(1);

   always_comb begin
      nprog = prog_inc;
      nhead = head_ff;
      nlegs = legs_ff;
      nleg  = leg_ff;
      // turn at the end of a leg, lengthen after every second leg
      if (prog_inc >= leg_ff) begin
         nprog = '0;
         nhead = sgw_pkg::heading_type'(head_ff + 2'd1);
         nlegs = ~legs_ff;
         if (legs_ff) begin
            nleg = leg_ff + LEG_W'(1);
         end
      end
   end

   assign in_grid = ~nrow[POS_W-1] & ~ncol[POS_W-1]
                  & (nrow < POS_W'(span_r_ff)) & (ncol < POS_W'(span_c_ff));
   assign runaway      = ~in_grid & (nleg > sgw_pkg::LEG_LIMIT);
   assign cells_inc    = cells_ff + CNT_W'(1);
   assign still_active = cells_inc < total_ff;

   assign status.active  = active_ff;
   assign status.found   = in_grid;
   assign status.runaway = runaway;

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      head_in     = head_ff;
      leg_in      = leg_ff;
      prog_in     = prog_ff;
      legs_in     = legs_ff;
      cells_in    = cells_ff;
      total_in    = total_ff;
      active_in   = active_ff;
      span_r_in   = span_r_ff;
      span_c_in   = span_c_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_last_in = out_last_ff;
      out_ex_in   = out_ex_ff;
      if (cmd.restart) begin
         span_r_in  = lim_r;
         span_c_in  = lim_c;
         total_in   = product[CNT_W-1:0];
         head_in    = sgw_pkg::HEAD_RIGHT;
         leg_in     = LEG_W'(1);
         prog_in    = '0;
         legs_in    = 1'b0;
         if (empty_grid) begin
            row_in      = '0;
            col_in      = '0;
            cells_in    = '0;
            active_in   = 1'b0;
            out_row_in  = '0;
            out_col_in  = '0;
            out_last_in = 1'b0;
            out_ex_in   = 1'b1;
         end else begin
            row_in      = POS_W'(sr);
            col_in      = POS_W'(sc);
            cells_in    = CNT_W'(1);
            active_in   = ~single_cell;
            out_row_in  = sr;
            out_col_in  = sc;
            out_last_in = single_cell;
            out_ex_in   = 1'b0;
         end
      end else if (cmd.exhaust) begin
         active_in   = 1'b0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_last_in = 1'b0;
         out_ex_in   = 1'b1;
      end else if (cmd.step) begin
         row_in  = nrow;
         col_in  = ncol;
         head_in = nhead;
         leg_in  = nleg;
         prog_in = nprog;
         legs_in = nlegs;
         if (in_grid) begin
            cells_in    = cells_inc;
            active_in   = still_active;
            out_row_in  = nrow[IDX_W-1:0];
            out_col_in  = ncol[IDX_W-1:0];
            out_last_in = ~still_active;
            out_ex_in   = 1'b0;
         end else if (runaway) begin
            active_in   = 1'b0;
            out_row_in  = '0;
            out_col_in  = '0;
            out_last_in = 1'b0;
            out_ex_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         col_ff    <= '0;
         head_ff   <= sgw_pkg::HEAD_RIGHT;
         leg_ff    <= LEG_W'(1);
         prog_ff   <= '0;
         legs_ff   <= 1'b0;
         cells_ff  <= '0;
         total_ff  <= '0;
         active_ff <= 1'b0;
         span_r_ff <= '0;
         span_c_ff <= '0;
      end else begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         head_ff   <= head_in;
         leg_ff    <= leg_in;
         prog_ff   <= prog_in;
         legs_ff   <= legs_in;
         cells_ff  <= cells_in;
         total_ff  <= total_in;
         active_ff <= active_in;
         span_r_ff <= span_r_in;
         span_c_ff <= span_c_in;
      end
   end

   always_ff @(posedge clock) begin
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_last_ff <= out_last_in;
      out_ex_ff   <= out_ex_in;
   end

   assign cell_row  = out_row_ff;
   assign cell_col  = out_col_ff;
   assign last_cell = out_last_ff;
   assign exhausted = out_ex_ff;

endmodule

/* rtl/spiral_grid_walker_core.sv */
// Top level of the spiral grid walker: configuration, controller and datapath.
//
// Hands out the cells of a grid_rows x grid_cols grid (each clamped to 128) one per
// request transaction, in clockwise outward spiral order (right, down, left, up, leg
// length growing after every second leg) from the start cell, which is clamped into
// the grid. A restart transaction begins a new walk and answers with the start cell
// (with exhausted for an empty grid); the cell that completes the grid carries
// last_cell, and any later request, or one before the first restart, answers with
// exhausted and zero coordinates. Grid size and start cell are sampled at restart.
// Work on one request at a time: an accepted request is executed once the output
// register is free; a restart or exhausted answer is then loaded into the result
// register directly, and a next-cell answer when the spiral reaches the next in-grid
// cell, since the datapath advances the spiral by one position per clock while the
// output register is free. The controller is ready for the next request as the
// answer is loaded. A result waiting in the output register does not block
// acceptance of the next request, but its processing holds until the result is taken.
// No clearing pass follows reset.
module spiral_grid_walker_core (
   input  logic                              clock,
   input  logic                              reset,
   sgw_req_if.sink                           req_if,
   sgw_rsp_if.source                         rsp_if,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sgw_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sgw_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sgw_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   sgw_pkg::cfg_type    cfg;
   sgw_pkg::cmd_type    cmd;
   sgw_pkg::status_type status;

   // configuration registers; the user is to write them only while idle, the block does not enforce it
   sgw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequence each request: latch it, step until a result, hand off
   sgw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_restart (req_if.restart),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // walk state, bounds check and the result register
   sgw_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .cell_row  (rsp_if.cell_row),
      .cell_col  (rsp_if.cell_col),
      .last_cell (rsp_if.last_cell),
      .exhausted (rsp_if.exhausted)
   );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the spiral grid walker: directed table, random walks, scoreboard.
`timescale 1ns / 1ps

module tb_top;

   // Run shape
   localparam int ITEM_TARGET    = 1850;   // request transactions to offer in total
   localparam int QUIET_TAIL     = 250;    // last requests run with no idling on either side
   localparam int HOLD_AT        = 700;    // results checked before the long receiver hold-off
   localparam int HOLD_CYCLES    = 400;    // length of that hold-off
   localparam int DRAIN_CYCLES   = 20;     // settle time once nothing is outstanding
   localparam int WATCHDOG_LIMIT = 20000;  // cycles with no transaction on either channel
   localparam int MAX_REPORTS    = 10;
   localparam int DIRECTED_ROWS  = 41;

   // One answer of the walker, laid out as the result channel carries it
   typedef struct packed {
      logic [sgw_pkg::IDX_W-1:0] row;
      logic [sgw_pkg::IDX_W-1:0] col;
      logic                      last;
      logic                      exhausted;
   } cell_answer_type;

   typedef enum logic {
      ROW_CSR = 1'b0,
      ROW_REQ = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      sgw_pkg::csr_addr_type addr;
      logic [7:0]            value;
      logic                  restart;
      logic                  typed;    // want holds the answer, else the predictor supplies it
      cell_answer_type       want;
   } stim_row_type;

   localparam cell_answer_type NO_ANSWER        = '0;
   localparam cell_answer_type EXHAUSTED_ANSWER = '{7'd0, 7'd0, 1'b0, 1'b1};

   logic clock = 1'b0;
   logic reset;

   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [sgw_pkg::CSR_ADDR_W-1:0] paddr;
   logic [sgw_pkg::CSR_DATA_W-1:0] pwdata;
   logic [sgw_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   sgw_req_if req_bus ();
   sgw_rsp_if rsp_bus ();

   spiral_grid_walker_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus.sink),
      .rsp_if  (rsp_bus.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Walk predictor: shadow registers plus its own copy of the walk state
   // ------------------------------------------------------------------
   sgw_pkg::cfg_type                 cfg_shadow;
   logic [sgw_pkg::DIM_W-1:0]        span_r;       // grid size latched at restart, clamped
   logic [sgw_pkg::DIM_W-1:0]        span_c;
   logic signed [sgw_pkg::POS_W-1:0] pos_row;
   logic signed [sgw_pkg::POS_W-1:0] pos_col;
   sgw_pkg::heading_type             dir;
   logic [sgw_pkg::LEG_W-1:0]        leg_len;
   logic                             leg_pair;     // toggles per leg, length grows on every second
   logic [sgw_pkg::LEG_W-1:0]        leg_steps;
   logic [sgw_pkg::CNT_W-1:0]        handed_out;
   logic                             walking;

   cell_answer_type pending_cells[$];     // answers still owed by the block

   // Compute the answer to one request and advance the shadow walk.
   function automatic void next_spiral_cell(input logic restart,
                                            output cell_answer_type ans);
      int total;
      int r_i;
      int c_i;
      ans = EXHAUSTED_ANSWER;
      if (restart) begin
         // Latch the grid, clamping oversized dimensions to the largest supported one
         span_r     = (cfg_shadow.grid_rows > sgw_pkg::MAX_DIM_V) ? sgw_pkg::MAX_DIM_V
                                                                  : cfg_shadow.grid_rows;
         span_c     = (cfg_shadow.grid_cols > sgw_pkg::MAX_DIM_V) ? sgw_pkg::MAX_DIM_V
                                                                  : cfg_shadow.grid_cols;
         dir        = sgw_pkg::HEAD_RIGHT;
         leg_len    = sgw_pkg::LEG_W'(1);
         leg_pair   = 1'b0;
         leg_steps  = '0;
         handed_out = '0;
         walking    = 1'b0;
         pos_row    = '0;
         pos_col    = '0;
         // An empty grid answers exhausted straight away
         if (span_r == '0 || span_c == '0) return;
         // Saturate a start cell beyond the grid onto its last row or column
         ans.row = ({1'b0, cfg_shadow.start_row} < span_r) ? cfg_shadow.start_row
                                                             : sgw_pkg::IDX_W'(span_r - 1'b1);
         ans.col = ({1'b0, cfg_shadow.start_col} < span_c) ? cfg_shadow.start_col
                                                             : sgw_pkg::IDX_W'(span_c - 1'b1);
         pos_row    = {3'b000, ans.row};
         pos_col    = {3'b000, ans.col};
         handed_out = sgw_pkg::CNT_W'(1);
         total      = int'(span_r) * int'(span_c);
         walking    = (total > 1);
         ans.last      = !walking;
         ans.exhausted = 1'b0;
         return;
      end
      total = int'(span_r) * int'(span_c);
      // Step the spiral until it lands inside the grid or gives up
      while (walking && int'(handed_out) < total) begin
         case (dir)
            sgw_pkg::HEAD_RIGHT: pos_col = pos_col + sgw_pkg::POS_W'(1);
            sgw_pkg::HEAD_DOWN:  pos_row = pos_row + sgw_pkg::POS_W'(1);
            sgw_pkg::HEAD_LEFT:  pos_col = pos_col - sgw_pkg::POS_W'(1);
            default:             pos_row = pos_row - sgw_pkg::POS_W'(1);
         endcase
         leg_steps = leg_steps + 1'b1;
         if (leg_steps >= leg_len) begin
            leg_steps = '0;
            dir       = sgw_pkg::heading_type'(dir + 2'd1);
            leg_pair  = ~leg_pair;
            if (!leg_pair) leg_len = leg_len + 1'b1;
         end
         r_i = pos_row;
         c_i = pos_col;
         if (r_i >= 0 && c_i >= 0 && r_i < int'(span_r) && c_i < int'(span_c)) begin
            handed_out = handed_out + 1'b1;
            if (int'(handed_out) >= total) walking = 1'b0;
            ans.row       = r_i[sgw_pkg::IDX_W-1:0];
            ans.col       = c_i[sgw_pkg::IDX_W-1:0];
            ans.last      = !walking;
            ans.exhausted = 1'b0;
            return;
         end
         // Runaway spiral: drop the walk once the legs outgrow any grid
         if (leg_len > sgw_pkg::LEG_LIMIT) walking = 1'b0;
      end
      walking = 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Shared run status
   // ------------------------------------------------------------------
   logic idle_mode;          // random gaps allowed on both channels
   logic holding_results;    // long receiver hold-off in progress
   int   items_sent;
   int   restarts_sent;
   int   phases;
   int   cells_checked;
   int   last_seen;
   int   exhausted_seen;
   int   error_count;

   // ------------------------------------------------------------------
   // Result side: scoreboard and receiver stalls
   // ------------------------------------------------------------------
   task automatic check_cell();
      cell_answer_type got;
      cell_answer_type want;
      got = '{rsp_bus.cell_row, rsp_bus.cell_col, rsp_bus.last_cell, rsp_bus.exhausted};
      cells_checked++;
      if (got.last) last_seen++;
      if (got.exhausted) exhausted_seen++;
      if (pending_cells.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("[%0t] result with nothing expected: row %0d col %0d last %0b exh %0b",
                     $realtime, got.row, got.col, got.last, got.exhausted);
         return;
      end
      want = pending_cells.pop_front();
      if (got.row !== want.row || got.col !== want.col ||
          got.last !== want.last || got.exhausted !== want.exhausted) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("[%0t] result %0d: expected row %0d col %0d last %0b exh %0b,",
                     $realtime, cells_checked, want.row, want.col, want.last,
                     want.exhausted,
                     " got row %0d col %0d last %0b exh %0b",
                     got.row, got.col, got.last, got.exhausted);
      end
   endtask

   int  stall_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) check_cell();
      // Hold off once for a long stretch, while requests are offered, so the block
      // backs up into its input
      if (!hold_done && cells_checked >= HOLD_AT && req_bus.valid) begin
         hold_done       = 1'b1;
         holding_results = 1'b1;
         stall_left      = HOLD_CYCLES;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) holding_results = 1'b0;
      end else if (idle_mode && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 16);
      end
      rsp_bus.ready <= (stall_left == 0);
   end

   // Watchdog: end the run if the channels go quiet for too long
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] timeout: no transaction for %0d cycles, %0d results outstanding",
                  $realtime, quiet_cycles, pending_cells.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request side and configuration
   // ------------------------------------------------------------------

   // Offer one request, wait for its transaction, then log the answer it is owed.
   task automatic send_request(input logic restart_bit, input logic typed,
                               input cell_answer_type typed_want);
      cell_answer_type predicted;
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart_bit;
      do @(posedge clock); while (!req_bus.ready);
      next_spiral_cell(restart_bit, predicted);
      pending_cells.push_back(typed ? typed_want : predicted);
      items_sent++;
      if (restart_bit) restarts_sent++;
      // Keep offering while the receiver is held off, so the block fills up
      if (idle_mode && !holding_results && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed answer has arrived.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register: setup cycle, then access cycle until pready.
   task automatic write_csr(input sgw_pkg::csr_addr_type idx, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= sgw_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         sgw_pkg::REG_GRID_ROWS: cfg_shadow.grid_rows = value;
         sgw_pkg::REG_GRID_COLS: cfg_shadow.grid_cols = value;
         sgw_pkg::REG_START_ROW: cfg_shadow.start_row = value[sgw_pkg::IDX_W-1:0];
         default:                cfg_shadow.start_col = value[sgw_pkg::IDX_W-1:0];
      endcase
   endtask

   // Directed part: reset values, empty, oversized and clamped grids, writes during a walk
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // before any restart, then the 1 x 1 grid left by reset
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b1, EXHAUSTED_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b1, 1'b1, '{7'd0, 7'd0, 1'b1, 1'b0}},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b1, EXHAUSTED_ANSWER},
      // empty grid
      '{ROW_CSR, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b1, 1'b1, EXHAUSTED_ANSWER},
      // full walk of a 3 x 3 grid from its center, then one past the end
      '{ROW_CSR, sgw_pkg::REG_GRID_ROWS, 8'd3,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_GRID_COLS, 8'd3,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_START_ROW, 8'd1,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_START_COL, 8'd1,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b1, 1'b1, '{7'd1, 7'd1, 1'b0, 1'b0}},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b1, EXHAUSTED_ANSWER},
      // oversized rows, single column, start column saturates onto column 0
      '{ROW_CSR, sgw_pkg::REG_GRID_ROWS, 8'd200, 1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_GRID_COLS, 8'd1,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_START_ROW, 8'd127, 1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_START_COL, 8'd127, 1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b1, 1'b1, '{7'd127, 7'd0, 1'b0, 1'b0}},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      // a write during the walk must not disturb it
      '{ROW_CSR, sgw_pkg::REG_START_ROW, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      // 1 x 2 grid, start column beyond the grid
      '{ROW_CSR, sgw_pkg::REG_GRID_ROWS, 8'd1,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_GRID_COLS, 8'd2,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_START_COL, 8'd5,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b1, 1'b1, '{7'd0, 7'd1, 1'b0, 1'b0}},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b1, EXHAUSTED_ANSWER},
      // largest grid from its far corner
      '{ROW_CSR, sgw_pkg::REG_GRID_ROWS, 8'd128, 1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_GRID_COLS, 8'd128, 1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_START_ROW, 8'd127, 1'b0, 1'b0, NO_ANSWER},
      '{ROW_CSR, sgw_pkg::REG_START_COL, 8'd127, 1'b0, 1'b0, NO_ANSWER},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b1, 1'b1, '{7'd127, 7'd127, 1'b0, 1'b0}},
      '{ROW_REQ, sgw_pkg::REG_GRID_ROWS, 8'd0,   1'b0, 1'b0, NO_ANSWER}
   };

   initial begin
      logic       wide_grid;
      logic       keep_walk;
      logic [7:0] rows_v;
      logic [7:0] cols_v;
      logic [7:0] srow_v;
      logic [7:0] scol_v;
      int         walk_len;

      // Drive every input to a known value before the first edge
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready   = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      idle_mode       = 1'b1;
      holding_results = 1'b0;
      items_sent      = 0;
      restarts_sent   = 0;
      phases          = 0;
      cells_checked   = 0;
      last_seen       = 0;
      exhausted_seen  = 0;
      error_count     = 0;
      cfg_shadow      = '{grid_rows: 8'd1, grid_cols: 8'd1, start_row: '0, start_col: '0};
      span_r          = '0;
      span_c          = '0;
      pos_row         = '0;
      pos_col         = '0;
      dir             = sgw_pkg::HEAD_RIGHT;
      leg_len         = sgw_pkg::LEG_W'(1);
      leg_pair        = 1'b0;
      leg_steps       = '0;
      handed_out      = '0;
      walking         = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; registers are only touched once the block is idle
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_for_drain();
            write_csr(directed_rows[i].addr, directed_rows[i].value);
         end else begin
            send_request(directed_rows[i].restart, directed_rows[i].typed,
                         directed_rows[i].want);
         end
      end

      // Random phases: new settings, usually a restart, then mostly a clean walk to the end
      while (items_sent < ITEM_TARGET) begin
         wait_for_drain();
         phases++;
         idle_mode = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         wide_grid = ($urandom_range(0, 7) == 0);
         keep_walk = ($urandom_range(0, 5) == 0);
         rows_v = wide_grid ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 8));
         cols_v = wide_grid ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 8));
         srow_v = wide_grid ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 9));
         scol_v = wide_grid ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 9));
         write_csr(sgw_pkg::REG_GRID_ROWS, rows_v);
         write_csr(sgw_pkg::REG_GRID_COLS, cols_v);
         write_csr(sgw_pkg::REG_START_ROW, srow_v);
         write_csr(sgw_pkg::REG_START_COL, scol_v);
         // Large grids walk only a short way; small ones run a little past the end
         walk_len = wide_grid ? $urandom_range(1, 40)
                              : int'(rows_v) * int'(cols_v) + $urandom_range(0, 3);
         // Sometimes carry on the previous walk under the new settings
         if (!keep_walk) send_request(1'b1, 1'b0, NO_ANSWER);
         repeat (walk_len) send_request($urandom_range(0, 29) == 0, 1'b0, NO_ANSWER);
      end

      idle_mode = 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d requests (%0d restarts) over %0d random settings plus the table",
               items_sent, restarts_sent, phases);
      $display("Answers: %0d checked, %0d final cells, %0d exhausted, %0d mismatches",
               cells_checked, last_seen, exhausted_seen, error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
